[rtl/core/arm_store_unit_core_assert.svh]
// Assertion macros used by the store unit checker.
`ifndef ARM_STORE_UNIT_CORE_ASSERT_SVH
`define ARM_STORE_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ASU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/asu_pkg.sv]
// Types, constants and helper functions of the ARM store unit.
package asu_pkg;

    localparam int NUM_REGS = 16;

    localparam logic [2:0] ST_STORE   = 3'd0;
    localparam logic [2:0] ST_NOMATCH = 3'd1;
    localparam logic [2:0] ST_OTHER   = 3'd2;
    localparam logic [2:0] ST_UNPRED  = 3'd3;
    localparam logic [2:0] ST_PC      = 3'd4;

    localparam logic [3:0] REG_PC = 4'd15;

    localparam logic       KIND_LOAD = 1'b0;
    localparam logic       KIND_EXEC = 1'b1;

    localparam logic [5:0] OP_STMDB = 6'h24;
    localparam logic [2:0] OP_STR   = 3'b010;

    typedef struct packed {
        logic        kind;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
        logic [31:0] instr_word;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic        mem_valid;
        logic [31:0] mem_address;
        logic [31:0] mem_data;
        logic        last;
        logic        wb_valid;
        logic [3:0]  wb_reg;
        logic [31:0] wb_value;
    } t_out_beat;

    // Number of set bits in a register list.
    function automatic logic [4:0] list_count(input logic [15:0] list);
        logic [4:0] cnt;
        cnt = '0;
        for (int i = 0; i < 16; i++) begin
            cnt = cnt + {4'd0, list[i]};
        end
        return cnt;
    endfunction

    // Index of the lowest set bit of a register list.
    function automatic logic [3:0] list_lowest(input logic [15:0] list);
        logic [3:0] idx;
        idx = '0;
        for (int i = 15; i >= 0; i--) begin
            if (list[i]) begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/core/arm_store_unit_core.sv]
// Top level of the ARM store unit: register file, decoder and store sequencer.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+--------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_beat)
//  out     | output    | o_out_valid / i_out_stall  | o_out_data (t_out_beat)
//
// A register load is written from the idle state; a rejected word goes straight
// to the output state. STR passes the base, data and output states, STMDB the
// base state, then store-data and output once per listed register. Reset
// clears the sequencer and the valid bits of the register file, so all
// registers read as zero until written. The input is stalled while an
// instruction is in flight, and a stalled output beat holds its value.
module arm_store_unit_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  asu_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output asu_pkg::t_out_beat o_out_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_BASE  = 5'b00010,
        S_DATA  = 5'b00100,
        S_SDATA = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [3:0]         r_rn, n_rn;
    logic [3:0]         r_rt, n_rt;
    logic               r_p, n_p;
    logic               r_u, n_u;
    logic               r_wb, n_wb;
    logic [11:0]        r_imm, n_imm;
    logic               r_is_stm, n_is_stm;
    logic [4:0]         r_cnt, n_cnt;
    logic [15:0]        r_list, n_list;
    logic               r_last, n_last;
    logic [31:0]        r_addr, n_addr;
    logic [31:0]        r_start, n_start;
    asu_pkg::t_out_beat r_out, n_out;

    logic [31:0]        r_mem [asu_pkg::NUM_REGS];
    logic [asu_pkg::NUM_REGS-1:0] r_vld;
    logic [31:0]        r_rd_data;
    logic               r_rd_hit;
    logic [31:0]        rd_val;
    logic [3:0]         rd_addr;
    logic               mem_we;
    logic [3:0]         mem_waddr;
    logic [31:0]        mem_wdata;

    logic [31:0]        add_a, add_b, add_sum;
    logic               add_sub;

    logic               in_take;
    logic [31:0]        w;
    logic               wback_in, is_str, is_stm;
    logic [15:0]        list_rest;

    assign o_in_stall  = !r_state[0] || !i_rst_n;
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

    assign in_take  = i_in_valid && !o_in_stall;
    assign w        = i_in_data.instr_word;
    assign wback_in = !w[24] || w[21];
    assign is_str   = (w[27:25] == asu_pkg::OP_STR) && !w[22] && !w[20];
    assign is_stm   = (w[27:22] == asu_pkg::OP_STMDB) && !w[20];

    // An entry that was never written since reset reads as zero.
    assign rd_val    = r_rd_hit ? r_rd_data : '0;
    assign list_rest = r_list & (r_list - 16'd1);

    // The one adder, shared by address and writeback arithmetic.
    assign add_sum = add_a + (add_b ^ {32{add_sub}}) + {31'd0, add_sub};

    always_comb begin
        n_state  = r_state;
        n_rn     = r_rn;
        n_rt     = r_rt;
        n_p      = r_p;
        n_u      = r_u;
        n_wb     = r_wb;
        n_imm    = r_imm;
        n_is_stm = r_is_stm;
        n_cnt    = r_cnt;
        n_list   = r_list;
        n_last   = r_last;
        n_addr   = r_addr;
        n_start  = r_start;
        n_out    = r_out;
        rd_addr  = w[19:16];
        mem_we   = 1'b0;
        mem_waddr = i_in_data.reg_index;
        mem_wdata = i_in_data.reg_value;
        add_a    = r_addr;
        add_b    = 32'd4;
        add_sub  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (i_in_data.kind == asu_pkg::KIND_LOAD) begin
                        mem_we = 1'b1;
                    end else begin
                        n_rn     = w[19:16];
                        n_rt     = w[15:12];
                        n_p      = w[24];
                        n_u      = w[23];
                        n_wb     = w[21];
                        n_imm    = w[11:0];
                        n_list   = w[15:0];
                        n_cnt    = asu_pkg::list_count(w[15:0]);
                        n_is_stm = !is_str;
                        n_last   = 1'b1;
                        n_out    = '0;
                        n_out.last = 1'b1;
                        n_state  = S_OUT;
                        priority if (is_str) begin
                            if (!w[24] && w[21]) begin
                                n_out.status = asu_pkg::ST_OTHER;
                            end else if (wback_in && (w[19:16] == w[15:12] ||
                                                      w[19:16] == asu_pkg::REG_PC)) begin
                                n_out.status = asu_pkg::ST_UNPRED;
                            end else if (w[19:16] == asu_pkg::REG_PC) begin
                                n_out.status = asu_pkg::ST_PC;
                            end else begin
                                n_state = S_BASE;
                            end
                        end else if (is_stm) begin
                            if (w[19:16] == asu_pkg::REG_PC || w[15:0] == 16'd0) begin
                                n_out.status = asu_pkg::ST_UNPRED;
                            end else if (w[15]) begin
                                n_out.status = asu_pkg::ST_PC;
                            end else begin
                                n_state = S_BASE;
                            end
                        end else begin
                            n_out.status = asu_pkg::ST_NOMATCH;
                        end
                    end
                end
            end
            S_BASE: begin
                // Base value is on the read port now.
                add_a = rd_val;
                if (r_is_stm) begin
                    add_b   = {25'd0, r_cnt, 2'b00};
                    add_sub = 1'b1;
                    n_addr  = add_sum;
                    n_start = add_sum;
                    rd_addr = asu_pkg::list_lowest(r_list);
                    n_list  = list_rest;
                    n_last  = (list_rest == 16'd0);
                    n_state = S_SDATA;
                end else begin
                    add_b   = {20'd0, r_imm};
                    add_sub = !r_u;
                    n_start = add_sum;
                    n_addr  = r_p ? add_sum : rd_val;
                    rd_addr = r_rt;
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                n_out.status      = asu_pkg::ST_STORE;
                n_out.mem_valid   = 1'b1;
                n_out.mem_address = r_addr;
                n_out.mem_data    = rd_val;
                n_out.last        = 1'b1;
                n_out.wb_valid    = !r_p || r_wb;
                n_out.wb_reg      = (!r_p || r_wb) ? r_rn : 4'd0;
                n_out.wb_value    = (!r_p || r_wb) ? r_start : 32'd0;
                mem_we            = !r_p || r_wb;
                mem_waddr         = r_rn;
                mem_wdata         = r_start;
                n_last            = 1'b1;
                n_state           = S_OUT;
            end
            S_SDATA: begin
                n_out.status      = asu_pkg::ST_STORE;
                n_out.mem_valid   = 1'b1;
                n_out.mem_address = r_addr;
                n_out.mem_data    = rd_val;
                n_out.last        = r_last;
                n_out.wb_valid    = r_last && r_wb;
                n_out.wb_reg      = (r_last && r_wb) ? r_rn : 4'd0;
                n_out.wb_value    = (r_last && r_wb) ? r_start : 32'd0;
                // Writeback only after every listed register has been read.
                mem_we            = r_last && r_wb;
                mem_waddr         = r_rn;
                mem_wdata         = r_start;
                n_addr            = add_sum;
                n_state           = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_addr = asu_pkg::list_lowest(r_list);
                        n_list  = list_rest;
                        n_last  = (list_rest == 16'd0);
                        n_state = S_SDATA;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_vld[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && i_rst_n) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_hit  <= r_vld[rd_addr] && i_rst_n;
    end

    always_ff @(posedge i_clk) begin
        r_rn     <= n_rn;
        r_rt     <= n_rt;
        r_p      <= n_p;
        r_u      <= n_u;
        r_wb     <= n_wb;
        r_imm    <= n_imm;
        r_is_stm <= n_is_stm;
        r_cnt    <= n_cnt;
        r_list   <= n_list;
        r_last   <= n_last;
        r_addr   <= n_addr;
        r_start  <= n_start;
        r_out    <= n_out;
    end

endmodule

[rtl/core/asu_checker.sv]
// Port-level checker of the ARM store unit and its bind to the top level.
`include "arm_store_unit_core_assert.svh"

module asu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input asu_pkg::t_in_beat  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input asu_pkg::t_out_beat o_out_data
);

    `ASU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled output beat changed")
    `ASU_ASSERT_NOW(a_busy_stall, i_clk, i_rst_n, o_out_valid, o_in_stall, "input taken while a result is pending")
    `ASU_ASSERT_NOW(a_wb_last, i_clk, i_rst_n, o_out_valid && o_out_data.wb_valid, o_out_data.last && o_out_data.status == asu_pkg::ST_STORE, "writeback on a beat that is not the last store")
    `ASU_ASSERT_NOW(a_reject_clean, i_clk, i_rst_n, o_out_valid && !o_out_data.mem_valid, o_out_data.last && o_out_data.status != asu_pkg::ST_STORE && !o_out_data.wb_valid && o_out_data.mem_address == 32'd0, "rejected beat is not a clean single result")
    `ASU_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_data.kind == asu_pkg::KIND_LOAD, !o_out_valid && !o_in_stall, "register load produced a result or stalled")

endmodule

bind arm_store_unit_core asu_checker u_asu_checker (.*);
